// File: src/rsst_pkg.sv
package rsst_pkg;

    // Capacity of the member table and the widths that follow from it.
    localparam int MAX_MEMBERS = 64;
    localparam int IDX_W       = $clog2(MAX_MEMBERS);
    localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
    localparam int VALUE_W     = 32;
    localparam int DRAW_W      = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int DIV_CNT_W   = $clog2(DRAW_W);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_PRESENT = 3'd1,
        ST_ABSENT  = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    search_step;
        logic    div_step;
        logic    rd_sample;
        logic    rd_last;
        logic    wr_insert;
        logic    wr_move;
        logic    load_result;
        status_t result_status;
        logic    result_sample;
    } rsst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        opcode_t op;
        logic    hit;
        logic    miss;
        logic    div_last;
        logic    empty;
        logic    full;
        logic    out_busy;
    } rsst_sts_t;

endpackage

// File: src/rsst_if.sv
interface rsst_req_if import rsst_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           opcode;
    logic signed [VALUE_W-1:0] item_value;
    logic [DRAW_W-1:0]         random_draw;

    modport source (output valid, output opcode, output item_value, output random_draw,
                    input ready);
    modport sink (input valid, input opcode, input item_value, input random_draw,
                  output ready);
endinterface

interface rsst_rsp_if import rsst_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] sampled_value;

    modport source (output valid, output status, output sampled_value, input ready);
    modport sink (input valid, input status, input sampled_value, output ready);
endinterface

// File: src/rsst_datapath.sv
module rsst_datapath import rsst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  rsst_cmd_t                 cmd,
    output rsst_sts_t                 sts,
    input  logic [OP_W-1:0]           opcode,
    input  logic [VALUE_W-1:0]        item_value,
    input  logic [DRAW_W-1:0]         random_draw,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [STATUS_W-1:0]       out_status,
    output logic [VALUE_W-1:0]        out_sample
);

    logic [VALUE_W-1:0]   mem [MAX_MEMBERS];
    logic [VALUE_W-1:0]   rd_data_reg;
    logic [OP_W-1:0]      op_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [DRAW_W-1:0]    draw_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [VALUE_W-1:0]   out_sample_reg;

    logic                 issue_search;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [VALUE_W-1:0]   wr_data;
    logic [CNT_W-1:0]     last_idx;
    logic [CNT_W:0]       rem_try;
    logic [CNT_W:0]       rem_sub;
    logic [CNT_W-1:0]     rem_next;
    logic                 hit;
    logic                 miss;
    logic                 out_busy;

    // Search issues one read per cycle while entries below the count remain.
    assign issue_search = cmd.search_step && (idx_reg < count_reg);
    assign hit          = pend_reg && (rd_data_reg == val_reg);
    assign miss         = !pend_reg && !(idx_reg < count_reg);
    assign last_idx     = count_reg - 1'b1;

    // Read and write port selection for the member table.
    assign rd_en = issue_search | cmd.rd_sample | cmd.rd_last;
    always_comb
    begin
        if (cmd.rd_last)
        begin
            rd_addr = last_idx[IDX_W-1:0];
        end
        else if (cmd.rd_sample)
        begin
            rd_addr = rem_reg[IDX_W-1:0];
        end
        else
        begin
            rd_addr = idx_reg[IDX_W-1:0];
        end
    end

    assign wr_en   = cmd.wr_insert | cmd.wr_move;
    assign wr_addr = cmd.wr_move ? slot_reg : count_reg[IDX_W-1:0];
    assign wr_data = cmd.wr_move ? rd_data_reg : val_reg;

    // One restoring step of the draw modulo count.
    assign rem_try  = {rem_reg, draw_reg[DRAW_W-1]};
    assign rem_sub  = rem_try - {1'b0, count_reg};
    assign rem_next = (rem_try >= {1'b0, count_reg}) ? rem_sub[CNT_W-1:0]
                                                     : rem_try[CNT_W-1:0];

    // Member table with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Item capture, search pointers and divider working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= opcode;
            val_reg     <= item_value;
            draw_reg    <= random_draw;
            idx_reg     <= '0;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (issue_search)
            begin
                idx_reg      <= idx_reg + 1'b1;
                pend_idx_reg <= idx_reg[IDX_W-1:0];
            end
            if (cmd.div_step)
            begin
                rem_reg     <= rem_next;
                draw_reg    <= {draw_reg[DRAW_W-2:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
        if (cmd.search_step && hit)
        begin
            slot_reg <= pend_idx_reg;
        end
    end

    // Control state: member count and the read-in-flight flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                pend_reg <= 1'b0;
            end
            else if (cmd.search_step)
            begin
                pend_reg <= issue_search;
            end
            if (cmd.wr_insert)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.wr_move)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Output register: holds a result until the receiver takes it.
    assign out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_status_reg <= cmd.result_status;
            out_sample_reg <= cmd.result_sample ? rd_data_reg : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_sample = out_sample_reg;

    assign sts.op       = opcode_t'(op_reg);
    assign sts.hit      = hit;
    assign sts.miss     = miss;
    assign sts.div_last = (div_cnt_reg == DIV_CNT_W'(DRAW_W - 1));
    assign sts.empty    = (count_reg == '0);
    assign sts.full     = (count_reg == CNT_W'(MAX_MEMBERS));
    assign sts.out_busy = out_busy;

    // The count never passes the table capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_MEMBERS))
        else $error("member count exceeds capacity");

    // A new result is never loaded over one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> !out_busy)
        else $error("result loaded while output is stalled");

    // An insert grows the count by exactly one.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_insert |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("insert did not advance the count");

    // A removal only happens with at least one member present.
    a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_move |-> count_reg != '0)
        else $error("removal from an empty table");

endmodule

// File: src/rsst_ctrl.sv
module rsst_ctrl import rsst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  rsst_sts_t sts,
    output rsst_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_DISPATCH  = 8'b0000_0010,
        S_SEARCH    = 8'b0000_0100,
        S_DIVIDE    = 8'b0000_1000,
        S_SAMPLE_RD = 8'b0001_0000,
        S_MOVE_RD   = 8'b0010_0000,
        S_MOVE_WR   = 8'b0100_0000,
        S_RESULT    = 8'b1000_0000
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    status_t res_status_reg;
    status_t res_status_next;
    logic    res_sample_reg;
    logic    res_sample_next;

    // Next state and command decode.
    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_sample_next = res_sample_reg;
        cmd             = '0;
        cmd.result_status = res_status_reg;
        cmd.result_sample = res_sample_reg;
        req_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_status_next = ST_DONE;
                res_sample_next = 1'b0;
                case (sts.op)
                    OP_INSERT, OP_REMOVE:
                    begin
                        state_next = S_SEARCH;
                    end
                    OP_SAMPLE:
                    begin
                        if (sts.empty)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_DIVIDE;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (sts.hit)
                begin
                    if (sts.op == OP_INSERT)
                    begin
                        res_status_next = ST_PRESENT;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_MOVE_RD;
                    end
                end
                else if (sts.miss)
                begin
                    state_next = S_RESULT;
                    if (sts.op == OP_INSERT)
                    begin
                        if (sts.full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_insert = 1'b1;
                        end
                    end
                    else
                    begin
                        res_status_next = ST_ABSENT;
                    end
                end
            end
            S_MOVE_RD:
            begin
                cmd.rd_last = 1'b1;
                state_next  = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                cmd.wr_move = 1'b1;
                state_next  = S_RESULT;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_SAMPLE_RD;
                end
            end
            S_SAMPLE_RD:
            begin
                cmd.rd_sample   = 1'b1;
                res_sample_next = 1'b1;
                state_next      = S_RESULT;
            end
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_status_reg <= ST_DONE;
            res_sample_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_sample_reg <= res_sample_next;
        end
    end

    // A table write is only issued while resolving a search or a removal.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_insert |-> (state_reg == S_SEARCH && sts.miss && !sts.full))
        else $error("insert write outside a failed search");

    // A sample read always follows the last divider step.
    a_sample_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_sample |-> $past(cmd.div_step) && $past(sts.div_last))
        else $error("sample read before the modulo finished");

    // Accepting an item always starts the dispatch step.
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> state_reg == S_DISPATCH)
        else $error("accepted item was not dispatched");

endmodule

// File: src/random_sampling_set_table_unit.sv
// Randomized set of distinct signed 32-bit members with insert, remove and
// random sample operations, one item in flight at a time.
// Channel req carries opcode, item_value and random_draw; an item is taken
// when req.valid and req.ready are both high. req.ready is high only while
// the controller is idle.
// Channel rsp returns one result per item: status and sampled_value.
// Insert and remove search the table one entry per cycle through a
// registered read port, and a removal moves the last entry into the gap.
// Sample computes random_draw modulo count with a one-bit-per-cycle
// restoring divider and then reads the entry at the resulting index.
// Results sit in an output register, so the next item is accepted while a
// result waits; if rsp.ready stays low, the following result waits in the
// controller and no further item is taken.
// Reset empties the set at once; the table contents need no clearing.
module random_sampling_set_table_unit import rsst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rsst_req_if.sink   req,
    rsst_rsp_if.source rsp
);

    rsst_cmd_t          cmd;
    rsst_sts_t          sts;
    logic [VALUE_W-1:0] out_sample;

    rsst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rsst_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .opcode      (req.opcode),
        .item_value  (req.item_value),
        .random_draw (req.random_draw),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_status  (rsp.status),
        .out_sample  (out_sample)
    );

    assign rsp.sampled_value = out_sample;

endmodule
